// ===== design/sstg_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the stereo tone generator.
// Used by sstg_front, sstg_back and stereo_sine_tone_generator_unit; depends on nothing.
package sstg_pkg;

  // Sizing of the phase accumulators, the sine table and the table entries.
  localparam int PHASE_BITS      = 32;
  localparam int SINE_TABLE_BITS = 10;
  localparam int SAMPLE_BITS     = 16;

  localparam int QUARTER_LEN = 1 << (SINE_TABLE_BITS - 2);
  localparam int QADDR_W     = SINE_TABLE_BITS - 1;
  localparam int ROM_W       = SAMPLE_BITS - 1;

  // Fixed widths of the register and payload fields.
  localparam int STEP_W     = 32;
  localparam int GAIN_W     = 16;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W     = GAIN_W + ROM_W;

  // Sample formatting constants.
  localparam int S16_MAX    = 32767;
  localparam int U8_MAX_POS = 127;
  localparam int U8_MAX_NEG = 128;
  localparam int U8_OFFSET  = 128;
  localparam int U8_SHIFT   = SAMPLE_BITS + 14;

  // The queue depth must be a power of two so that the pointers wrap on their own.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam real PI = 3.14159265358979323846;

  // Angle between two neighboring entries of the full table.
  localparam real ANG_STEP = PI * 2.0 / real'(1 << SINE_TABLE_BITS);

  localparam logic [STEP_W-1:0] STEP_RESET = 32'd39370534;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEFT_STEP  = 3'd0,
    CFG_RIGHT_STEP = 3'd1,
    CFG_LEFT_GAIN  = 3'd2,
    CFG_RIGHT_GAIN = 3'd3,
    CFG_FORMAT     = 3'd4
  } cfg_reg_t;

  localparam logic FMT_U8  = 1'b0;
  localparam logic FMT_S16 = 1'b1;

  // Sign history codes of a channel.
  localparam logic [1:0] SIGN_ZERO = 2'd0;
  localparam logic [1:0] SIGN_POS  = 2'd1;
  localparam logic [1:0] SIGN_NEG  = 2'd3;

  typedef struct packed {
    logic stop;
    logic block_end;
  } frame_t;

  typedef struct packed {
    logic [STEP_W-1:0] left_step;
    logic [STEP_W-1:0] right_step;
    logic [GAIN_W-1:0] left_gain;
    logic [GAIN_W-1:0] right_gain;
    logic              fmt;
  } cfg_t;

  typedef logic [ROM_W-1:0] rom_word_t;
  typedef rom_word_t quarter_rom_t [0:QUARTER_LEN];

  // Quarter wave of sine, magnitude scaled to full sample range and rounded half up.
  function automatic quarter_rom_t build_quarter_rom();
    quarter_rom_t rom;
    real          amp;
    real          ang;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      amp    = real'((1 << (SAMPLE_BITS - 1)) - 1);
      ang    = ANG_STEP * real'(k);
      rom[k] = ROM_W'($rtoi($sin(ang) * amp + 0.5));
    end
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

endpackage

// ===== design/sstg_front.sv =====
// Front end of the tone generator: accepts frame words and queues them for the back end.
// Depends on sstg_pkg.
module sstg_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sstg_pkg::frame_t in_item,
  output logic            q_valid,
  input  logic            q_ready,
  output sstg_pkg::frame_t q_item
);
  import sstg_pkg::*;

  frame_t              mem_r [0:QUEUE_DEPTH-1];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                push;
  logic                pop;

  assign in_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= in_item;
        wr_ptr_r        <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== design/sstg_back.sv =====
// Back end of the tone generator: phase accumulators, shared table lookup and multiplier,
// stop handling, sample formatting and the output register. Depends on sstg_pkg.
module sstg_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sstg_pkg::cfg_t               cfg,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  sstg_pkg::frame_t             q_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sstg_pkg::OUT_W-1:0]   out_left_sample,
  output logic [sstg_pkg::OUT_W-1:0]   out_right_sample,
  output logic                         out_silent,
  output logic                         out_block_end_out
);
  import sstg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_DONE
  } state_t;

  localparam int M_W = PROD_W + 8;

  state_t                  state_r, state_nxt;
  frame_t                  item_r, item_nxt;
  logic [PHASE_BITS-1:0]   lphase_r, lphase_nxt, rphase_r, rphase_nxt;
  logic [1:0]              lsign_r, lsign_nxt, rsign_r, rsign_nxt;
  logic [PROD_W-1:0]       lmag_r, lmag_nxt, rmag_r, rmag_nxt;
  logic                    lneg_r, lneg_nxt, rneg_r, rneg_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]        left_r, left_nxt, right_r, right_nxt;
  logic                    silent_r, silent_nxt;
  logic                    bend_r, bend_nxt;

  logic [PHASE_BITS-1:0]       phase_sel;
  logic [GAIN_W-1:0]           gain_sel;
  logic [SINE_TABLE_BITS-1:0]  idx;
  logic [1:0]                  quad;
  logic [QADDR_W-1:0]          addr;
  rom_word_t                   rom_mag;
  logic [PROD_W-1:0]           prod;
  logic                        prod_neg;
  logic                        l_cross, r_cross, l_zero, r_zero;
  logic                        out_free;

  // Turns a signed product (magnitude and sign) into a 16-bit or offset 8-bit sample.
  function automatic logic [OUT_W-1:0] fmt_sample(input logic [PROD_W-1:0] mag,
                                                  input logic neg, input logic fmt);
    logic [PROD_W-1:0] q16;
    logic [OUT_W-1:0]  v16;
    logic [M_W-1:0]    m;
    logic [M_W-1:0]    q8;
    logic [OUT_W-1:0]  v8;
    q16 = mag >> (SAMPLE_BITS - 1);
    if (q16 > PROD_W'(S16_MAX)) q16 = PROD_W'(S16_MAX);
    v16 = neg ? -OUT_W'(q16) : OUT_W'(q16);
    m   = (M_W'(mag) << 7) - M_W'(mag);
    if (!neg) begin
      q8 = m >> U8_SHIFT;
      if (q8 > M_W'(U8_MAX_POS)) q8 = M_W'(U8_MAX_POS);
      v8 = OUT_W'(U8_OFFSET) + OUT_W'(q8);
    end else begin
      q8 = (m + ((M_W'(1) << U8_SHIFT) - M_W'(1))) >> U8_SHIFT;
      if (q8 > M_W'(U8_MAX_NEG)) q8 = M_W'(U8_MAX_NEG);
      v8 = OUT_W'(U8_OFFSET) - OUT_W'(q8);
    end
    return (fmt == FMT_S16) ? v16 : v8;
  endfunction

  // Shared table lookup and multiplier; the left channel uses it in ST_MUL_L, the right channel in ST_MUL_R.
  assign phase_sel = (state_r == ST_MUL_R) ? rphase_r : lphase_r;
  assign gain_sel  = (state_r == ST_MUL_R) ? cfg.right_gain : cfg.left_gain;
  assign idx       = phase_sel[PHASE_BITS-1 -: SINE_TABLE_BITS];
  assign quad      = idx[SINE_TABLE_BITS-1 -: 2];
  assign addr      = quad[0] ? QADDR_W'(QUARTER_LEN) - {1'b0, idx[SINE_TABLE_BITS-3:0]}
                             : {1'b0, idx[SINE_TABLE_BITS-3:0]};
  assign rom_mag   = QUARTER_ROM[addr];
  assign prod      = PROD_W'(gain_sel) * PROD_W'(rom_mag);
  assign prod_neg  = quad[1] && (prod != '0);

  // A channel crosses zero when its sign differs from the last one, or it was at rest.
  assign l_cross = (lsign_r == SIGN_ZERO) || (!lneg_r && lmag_r != '0 && lsign_r[1]) ||
                   (lneg_r && !lsign_r[1]);
  assign r_cross = (rsign_r == SIGN_ZERO) || (!rneg_r && rmag_r != '0 && rsign_r[1]) ||
                   (rneg_r && !rsign_r[1]);
  assign l_zero  = (item_r.stop && l_cross) || (lmag_r == '0);
  assign r_zero  = (item_r.stop && r_cross) || (rmag_r == '0);

  assign out_free = !out_valid_r || out_ready;
  assign q_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    lphase_nxt    = lphase_r;
    rphase_nxt    = rphase_r;
    lsign_nxt     = lsign_r;
    rsign_nxt     = rsign_r;
    lmag_nxt      = lmag_r;
    rmag_nxt      = rmag_r;
    lneg_nxt      = lneg_r;
    rneg_nxt      = rneg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    left_nxt      = left_r;
    right_nxt     = right_r;
    silent_nxt    = silent_r;
    bend_nxt      = bend_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          item_nxt  = q_item;
          state_nxt = ST_MUL_L;
        end
      end
      ST_MUL_L: begin
        lmag_nxt  = prod;
        lneg_nxt  = prod_neg;
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        rmag_nxt  = prod;
        rneg_nxt  = prod_neg;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          left_nxt      = fmt_sample(l_zero ? '0 : lmag_r, lneg_r && !l_zero, cfg.fmt);
          right_nxt     = fmt_sample(r_zero ? '0 : rmag_r, rneg_r && !r_zero, cfg.fmt);
          silent_nxt    = item_r.stop && l_zero && r_zero;
          bend_nxt      = item_r.block_end;
          lsign_nxt     = l_zero ? SIGN_ZERO : (lneg_r ? SIGN_NEG : SIGN_POS);
          rsign_nxt     = r_zero ? SIGN_ZERO : (rneg_r ? SIGN_NEG : SIGN_POS);
          lphase_nxt    = (item_r.stop && l_zero) ? '0
                                                  : lphase_r + PHASE_BITS'(cfg.left_step);
          rphase_nxt    = (item_r.stop && r_zero) ? '0
                                                  : rphase_r + PHASE_BITS'(cfg.right_step);
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lphase_r    <= '0;
      rphase_r    <= '0;
      lsign_r     <= SIGN_ZERO;
      rsign_r     <= SIGN_ZERO;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lphase_r    <= lphase_nxt;
      rphase_r    <= rphase_nxt;
      lsign_r     <= lsign_nxt;
      rsign_r     <= rsign_nxt;
      out_valid_r <= out_valid_nxt;
      item_r      <= item_nxt;
      lmag_r      <= lmag_nxt;
      rmag_r      <= rmag_nxt;
      lneg_r      <= lneg_nxt;
      rneg_r      <= rneg_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      silent_r    <= silent_nxt;
      bend_r      <= bend_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_left_sample   = left_r;
  assign out_right_sample  = right_r;
  assign out_silent        = silent_r;
  assign out_block_end_out = bend_r;

endmodule

// ===== design/stereo_sine_tone_generator_unit.sv =====
// Top level of the stereo sine tone generator: configuration registers, front queue, back end.
// Depends on sstg_pkg, sstg_front and sstg_back.
//
// Usage: every input word is one audio frame tick carrying a stop request and a block end
// marker. For each word the block returns exactly one output word with a left and a right
// sample, a silent flag and a copy of the block end marker. Samples are signed 16-bit, or
// 0 to 255 in offset 8-bit mode, as chosen by the format register.
// The configuration channel is always ready; it takes a register index and write data and
// must only be used while no frame is in flight.
// The back end shares one table lookup and one multiplier over both channels and takes
// one word at a time: it takes the word from the queue, works the left channel, then the
// right channel, then formats and writes back the output word, and only then takes the
// next word from the queue.
// The two-entry front queue keeps accepting frame words while the back end is busy or while
// a finished word waits in the output register. When the receiver stalls, the output word
// holds and the back end waits with its next result, so the queue fills and then in_ready
// drops. Synchronous reset clears both phases and sign histories, empties the queue and
// loads the register defaults (default step, zero gain, 16-bit format).
module stereo_sine_tone_generator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sstg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sstg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_stop_request,
  input  logic                                in_block_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sstg_pkg::OUT_W-1:0]   out_left_sample,
  output logic signed [sstg_pkg::OUT_W-1:0]   out_right_sample,
  output logic                                out_silent,
  output logic                                out_block_end_out
);
  import sstg_pkg::*;

  cfg_t   cfg_r;
  frame_t in_item;
  frame_t q_item;
  logic   q_valid;
  logic   q_ready;
  logic [OUT_W-1:0] left_word;
  logic [OUT_W-1:0] right_word;
  logic   stop_seen_r;

  // Every configuration write is taken as offered, so the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_step  <= STEP_RESET;
      cfg_r.right_step <= STEP_RESET;
      cfg_r.left_gain  <= '0;
      cfg_r.right_gain <= '0;
      cfg_r.fmt        <= FMT_S16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LEFT_STEP:  cfg_r.left_step  <= cfg_data[STEP_W-1:0];
        CFG_RIGHT_STEP: cfg_r.right_step <= cfg_data[STEP_W-1:0];
        CFG_LEFT_GAIN:  cfg_r.left_gain  <= cfg_data[GAIN_W-1:0];
        CFG_RIGHT_GAIN: cfg_r.right_gain <= cfg_data[GAIN_W-1:0];
        CFG_FORMAT:     cfg_r.fmt        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_item.stop      = in_stop_request;
  assign in_item.block_end = in_block_end;

  sstg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  sstg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_ready           (q_ready),
    .q_item            (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_sample   (left_word),
    .out_right_sample  (right_word),
    .out_silent        (out_silent),
    .out_block_end_out (out_block_end_out)
  );

  assign out_left_sample  = left_word;
  assign out_right_sample = right_word;

  // Tracks whether the back end has taken any stop request from the queue since reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_seen_r <= 1'b0;
    end else if (q_valid && q_ready && q_item.stop) begin
      stop_seen_r <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  // A silent frame in 16-bit mode carries zero samples on both channels.
  a_silent_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_silent && cfg_r.fmt == FMT_S16) |->
      (out_left_sample == '0 && out_right_sample == '0))
    else $error("silent word with nonzero samples");

  // In 8-bit mode both samples stay within 0 to 255.
  a_u8_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && cfg_r.fmt == FMT_U8) |->
      (out_left_sample[OUT_W-1:8] == '0 && out_right_sample[OUT_W-1:8] == '0))
    else $error("8-bit sample out of range");

  // Once the back end takes a word from the queue it is busy for the following cycle.
  a_back_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_ready) |=> !q_ready)
    else $error("back end took two words in a row");

  // The silent flag can only be raised by a frame that requested a stop.
  a_silent_needs_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid) && out_silent) |-> $past(stop_seen_r))
    else $error("silent word without a stop request");
`endif

endmodule

// ===== sim/testbench.sv =====
// Testbench for stereo_sine_tone_generator_unit: frame words in, stereo sample words out.
// It keeps its own copy of the two-channel synthesizer to predict every output word.
// Depends on sstg_pkg and the RTL under design/; reads no files.
`timescale 1ns / 1ps

module testbench;
  import sstg_pkg::*;

  // Output word as the block should produce it.
  typedef struct packed {
    logic signed [OUT_W-1:0] left;
    logic signed [OUT_W-1:0] right;
    logic                    silent;
    logic                    block_end;
  } tone_t;

  // One row of the directed plan. When load is set, the block is drained and the
  // register set is rewritten before the frame word goes in. When typed is set, the
  // output word is the one written in the row; otherwise the synthesizer copy decides.
  typedef struct {
    logic   load;
    cfg_t   regs;
    frame_t frame;
    logic   typed;
    tone_t  want;
  } plan_row_t;

  localparam int IDLE_PCT        = 12;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 12;
  localparam int RAND_PHASES     = 13;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int STEADY_FIRST    = 6;
  localparam int STEADY_LAST     = 7;
  localparam int PLAN_ROWS       = 22;

  // pi in Q60, and the peak value of a table entry.
  localparam longint unsigned PI_Q60     = 64'h3243F6A8885A308D;
  localparam longint unsigned SINE_PEAK  = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
  localparam logic [STEP_W-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam frame_t F_PLAY     = '{1'b0, 1'b0};
  localparam frame_t F_PLAY_END = '{1'b0, 1'b1};
  localparam frame_t F_STOP     = '{1'b1, 1'b0};
  localparam frame_t F_STOP_END = '{1'b1, 1'b1};

  localparam cfg_t NO_LOAD = '0;
  // A quarter turn per frame walks the table through zero, peak, zero and trough.
  // The right gain is the largest that the field holds, so its samples saturate.
  localparam cfg_t QTR_S16 = '{QUARTER_TURN, QUARTER_TURN, 16'd32768, 16'hFFFF, FMT_S16};
  localparam cfg_t QTR_U8  = '{QUARTER_TURN, QUARTER_TURN, 16'd32768, 16'hFFFF, FMT_U8};
  // The left phase runs backward by one each frame and wraps at once; the right one
  // jumps three eighths of a turn, so it changes sign on most frames.
  localparam cfg_t SKEW_S16 = '{32'hFFFF_FFFF, 32'h6000_0000, 16'd12345, 16'd32768, FMT_S16};

  plan_row_t plan [PLAN_ROWS] = '{
    // Reset values: zero gain, so every sample is zero; a stop word reports silence.
    '{1'b0, NO_LOAD, F_PLAY,     1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{1'b0, NO_LOAD, F_STOP_END, 1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b1}},
    '{1'b0, NO_LOAD, F_PLAY_END, 1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b1}},
    '{1'b0, NO_LOAD, F_STOP,     1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
    // Full scale and over-full scale in 16-bit format, then a stop from rest at the peak.
    '{1'b1, QTR_S16, F_PLAY,     1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{1'b0, NO_LOAD, F_PLAY_END, 1'b1, '{16'sd32767, 16'sd32767, 1'b0, 1'b1}},
    '{1'b0, NO_LOAD, F_PLAY,     1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{1'b0, NO_LOAD, F_PLAY,     1'b1, '{-16'sd32767, -16'sd32767, 1'b0, 1'b0}},
    '{1'b0, NO_LOAD, F_PLAY,     1'b1, '{16'sd0, 16'sd0, 1'b0, 1'b0}},
    '{1'b0, NO_LOAD, F_STOP,     1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b0}},
    // The same walk in offset 8-bit format; the right channel clamps at 255 and 0.
    '{1'b1, QTR_U8,  F_PLAY,     1'b1, '{16'sd128, 16'sd128, 1'b0, 1'b0}},
    '{1'b0, NO_LOAD, F_PLAY_END, 1'b1, '{16'sd254, 16'sd255, 1'b0, 1'b1}},
    '{1'b0, NO_LOAD, F_PLAY,     1'b1, '{16'sd128, 16'sd128, 1'b0, 1'b0}},
    '{1'b0, NO_LOAD, F_PLAY,     1'b1, '{16'sd1, 16'sd0, 1'b0, 1'b0}},
    '{1'b0, NO_LOAD, F_STOP,     1'b1, '{16'sd128, 16'sd128, 1'b1, 1'b0}},
    // Stop while both channels are moving: the right one crosses zero, the left does not.
    '{1'b1, SKEW_S16, F_PLAY,     1'b0, '0},
    '{1'b0, NO_LOAD,  F_PLAY_END, 1'b0, '0},
    '{1'b0, NO_LOAD,  F_STOP,     1'b0, '0},
    '{1'b0, NO_LOAD,  F_STOP_END, 1'b0, '0},
    '{1'b0, NO_LOAD,  F_PLAY,     1'b0, '0},
    '{1'b0, NO_LOAD,  F_STOP,     1'b0, '0},
    '{1'b0, NO_LOAD,  F_PLAY_END, 1'b0, '0}
  };

  // Block ports. Every input has a known value from time zero.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_stop_request = 1'b0;
  logic                  in_block_end = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_left_sample;
  logic signed [OUT_W-1:0] out_right_sample;
  logic                  out_silent;
  logic                  out_block_end_out;

  // State of the synthesizer copy: register set, phases and sign history per channel.
  cfg_t              regs = '{STEP_RESET, STEP_RESET, 16'd0, 16'd0, FMT_S16};
  logic [PHASE_BITS-1:0] phase_l = '0;
  logic [PHASE_BITS-1:0] phase_r = '0;
  logic [1:0]        sign_l = SIGN_ZERO;
  logic [1:0]        sign_r = SIGN_ZERO;
  int                sine_q [0:QUARTER_LEN];

  tone_t tone_fifo [$];
  tone_t due;
  logic  steady = 1'b0;
  int    errors = 0;
  int    frames_sent = 0;
  int    words_checked = 0;
  int    silent_frames = 0;
  int    settings_used = 0;
  int    stall_run = 0;

  stereo_sine_tone_generator_unit i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_stop_request   (in_stop_request),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_left_sample   (out_left_sample),
    .out_right_sample  (out_right_sample),
    .out_silent        (out_silent),
    .out_block_end_out (out_block_end_out)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Synthesizer copy
  // ---------------------------------------------------------------------------

  // Product of two Q60 numbers, kept in Q60.
  function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[123:60];
  endfunction

  // Quarter wave of the sine table, from an odd Taylor series in Q60 and rounded
  // half up to the sample magnitude. This is exact integer work, so the table does
  // not hinge on how a simulator rounds reals.
  function automatic void fill_sine_quarter();
    longint unsigned x, x2, term, acc;
    for (int k = 0; k <= QUARTER_LEN; k++) begin
      x    = ((PI_Q60 >> 1) >> (SINE_TABLE_BITS - 2)) * 64'(k);
      x2   = q60_mul(x, x);
      term = x;
      acc  = x;
      for (int n = 1; n <= 12; n++) begin
        term = q60_mul(term, x2) / (64'(2 * n) * 64'(2 * n + 1));
        if (n % 2 == 1) begin
          acc -= term;
        end else begin
          acc += term;
        end
      end
      sine_q[k] = int'(((acc >> 20) * SINE_PEAK + (64'd1 << 39)) >> 40);
    end
  endfunction

  // Signed table value at a phase; the top bits pick the quadrant and the entry.
  function automatic longint sine_at(logic [PHASE_BITS-1:0] ph);
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [SINE_TABLE_BITS-3:0] r;
    longint m;
    idx = ph[PHASE_BITS-1 -: SINE_TABLE_BITS];
    r   = idx[SINE_TABLE_BITS-3:0];
    m   = idx[SINE_TABLE_BITS-2] ? sine_q[QUARTER_LEN - r] : sine_q[r];
    return idx[SINE_TABLE_BITS-1] ? -m : m;
  endfunction

  // Turns a channel product into a sample: truncation toward zero in 16-bit format,
  // a floored scale plus offset in 8-bit format, each clamped to its range.
  function automatic logic [OUT_W-1:0] shape(longint p, logic fmt);
    longint unsigned mag, q;
    longint v;
    mag = p < 0 ? -p : p;
    if (fmt == FMT_S16) begin
      q = mag >> (SAMPLE_BITS - 1);
      if (q > S16_MAX) q = S16_MAX;
      v = p < 0 ? -longint'(q) : longint'(q);
    end else begin
      if (p >= 0) begin
        q = (mag * U8_MAX_POS) >> U8_SHIFT;
        v = q > U8_MAX_POS ? longint'(U8_MAX_POS) : longint'(q);
      end else begin
        q = (mag * U8_MAX_POS + ((64'd1 << U8_SHIFT) - 64'd1)) >> U8_SHIFT;
        v = q > U8_MAX_NEG ? -longint'(U8_MAX_NEG) : -longint'(q);
      end
      v += U8_OFFSET;
    end
    return v[OUT_W-1:0];
  endfunction

  function automatic logic [1:0] sign_of(longint p);
    return p > 0 ? SIGN_POS : (p < 0 ? SIGN_NEG : SIGN_ZERO);
  endfunction

  // A channel at rest counts as crossed at once; otherwise it crosses when the
  // product has the opposite sign of the last one.
  function automatic logic zero_crossed(longint p, logic [1:0] last);
    if (last == SIGN_ZERO) return 1'b1;
    return (p > 0 && last[1]) || (p < 0 && !last[1]);
  endfunction

  // Works out the output word for one frame and advances both channels.
  function automatic tone_t synth_frame(frame_t f);
    longint lp, rp;
    tone_t  t;
    lp = longint'(regs.left_gain) * sine_at(phase_l);
    rp = longint'(regs.right_gain) * sine_at(phase_r);
    if (f.stop) begin
      if (zero_crossed(lp, sign_l)) lp = 0;
      if (zero_crossed(rp, sign_r)) rp = 0;
      t.silent = (lp == 0 && rp == 0);
    end else begin
      t.silent = 1'b0;
    end
    sign_l      = sign_of(lp);
    sign_r      = sign_of(rp);
    t.left      = shape(lp, regs.fmt);
    t.right     = shape(rp, regs.fmt);
    t.block_end = f.block_end;
    phase_l     = phase_l + regs.left_step;
    phase_r     = phase_r + regs.right_step;
    // A channel held at zero during a stop starts again from phase zero.
    if (f.stop && lp == 0) phase_l = '0;
    if (f.stop && rp == 0) phase_r = '0;
    if (t.silent) silent_frames++;
    return t;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offers one frame word, maybe after an idle gap. Valid stays high from one word to
  // the next unless a gap is taken, so it is never lowered and raised in one step.
  task automatic send_frame(input frame_t f, input logic use_want, input tone_t want,
                            output tone_t got);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < IDLE_PCT);
    end
    in_valid        <= 1'b1;
    in_stop_request <= f.stop;
    in_block_end    <= f.block_end;
    do @(posedge clk); while (!in_ready);
    got = synth_frame(f);
    tone_fifo.push_back(use_want ? want : got);
    frames_sent++;
  endtask

  // Lets the block run dry: input idle and every expected word received.
  task automatic settle();
    in_valid <= 1'b0;
    while (tone_fifo.size() != 0) @(posedge clk);
  endtask

  // One register write; cfg_valid is left high for a following write.
  task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LEFT_STEP:  regs.left_step  = data[STEP_W-1:0];
      CFG_RIGHT_STEP: regs.right_step = data[STEP_W-1:0];
      CFG_LEFT_GAIN:  regs.left_gain  = data[GAIN_W-1:0];
      CFG_RIGHT_GAIN: regs.right_gain = data[GAIN_W-1:0];
      CFG_FORMAT:     regs.fmt        = data[0];
      default: ;
    endcase
  endtask

  // Writes the whole register set. The unused upper data bits carry noise, which
  // the block must drop.
  task automatic load_settings(input cfg_t s);
    put_reg(CFG_LEFT_STEP, s.left_step);
    put_reg(CFG_RIGHT_STEP, s.right_step);
    put_reg(CFG_LEFT_GAIN, {16'($urandom), s.left_gain});
    put_reg(CFG_RIGHT_GAIN, {16'($urandom), s.right_gain});
    put_reg(CFG_FORMAT, {31'($urandom), s.fmt});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Steps lean toward values large enough for a stop to reach a crossing quickly,
  // with the limits and a stopped phase mixed in.
  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(0, 6))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      3:       return $urandom;
      default: return $urandom_range(32'h7FFF_FFFF, 32'h0800_0000);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(32768, 1));
    endcase
  endfunction

  // The receiver drops ready now and then, except during the steady stretch.
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(string what, logic signed [OUT_W-1:0] want,
                                      logic signed [OUT_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // Every word taken from the block is held against the oldest expected word.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tone_fifo.size() == 0) begin
        $display("%0t: output word with none expected: left %0d right %0d silent %b end %b",
                 $time, out_left_sample, out_right_sample, out_silent, out_block_end_out);
        errors++;
      end else begin
        due = tone_fifo.pop_front();
        check_field("left sample", due.left, out_left_sample);
        check_field("right sample", due.right, out_right_sample);
        check_field("silent flag", due.silent, out_silent);
        check_field("block end", due.block_end, out_block_end_out);
        words_checked++;
      end
    end
  end

  // Watchdog: a long run of cycles in which no word moves on any channel means
  // the block is hung.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_run <= 0;
    end else if (stall_run == STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("stereo_sine_tone_generator_unit: mismatch");
      $finish;
    end else begin
      stall_run <= stall_run + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    tone_t got;
    cfg_t  s;
    int    n;
    int    cap;
    fill_sine_quarter();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan.
    foreach (plan[i]) begin
      if (plan[i].load) begin
        settle();
        load_settings(plan[i].regs);
      end
      send_frame(plan[i].frame, plan[i].typed, plan[i].want, got);
    end

    // Random phases, each with its own register set. The format alternates so both
    // are seen; two phases in the middle run without any idling on either side.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      s.left_step  = pick_step();
      s.right_step = pick_step();
      s.left_gain  = pick_gain();
      s.right_gain = pick_gain();
      s.fmt        = (ph % 2 == 0) ? FMT_U8 : FMT_S16;
      load_settings(s);
      steady = (ph >= STEADY_FIRST && ph <= STEADY_LAST);
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 8) begin
          // A tone burst, then a stop held until both channels fall silent (or a cap
          // is reached), then a few more stop words at rest.
          repeat ($urandom_range(2, 24)) begin
            send_frame(frame_t'{1'b0, 1'($urandom_range(7) == 0)}, 1'b0, '0, got);
            n++;
          end
          cap = 40;
          do begin
            send_frame(frame_t'{1'b1, 1'($urandom_range(7) == 0)}, 1'b0, '0, got);
            n++;
            cap--;
          end while (cap > 0 && !got.silent);
          repeat ($urandom_range(0, 3)) begin
            send_frame(frame_t'{1'b1, 1'($urandom_range(7) == 0)}, 1'b0, '0, got);
            n++;
          end
        end else begin
          // Noise: stop and block end bits at random.
          repeat ($urandom_range(1, 8)) begin
            send_frame(frame_t'(2'($urandom)), 1'b0, '0, got);
            n++;
          end
        end
      end
    end
    steady = 1'b0;

    // Drain, then give the block a short while to show any stray word.
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d of %0d frame words across %0d register sets, both sample formats,",
             words_checked, frames_sent, settings_used);
    $display("with steps and gains at their limits and %0d silent frames.", silent_frames);
    if (errors == 0 && tone_fifo.size() == 0) begin
      $display("stereo_sine_tone_generator_unit: match");
    end else begin
      $display("stereo_sine_tone_generator_unit: mismatch");
    end
    $finish;
  end

endmodule
